// ===== rtl/mtfq_pkg.sv =====
package mtfq_pkg;

	localparam int ID_W      = 30;
	localparam int CMD_W     = 2;
	localparam int DEPTH_DEF = 1024;

	localparam logic [CMD_W-1:0] CMD_SERVE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXPEDITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART  = 2'd2;

endpackage

// ===== rtl/move_to_front_service_queue.sv =====
// Channel  | Direction | Beat contents
// ---------+-----------+---------------------------------------------------
// s_*      | in        | s_tdata: cmd [1:0], target_id [31:2]
// m_*      | out       | m_tdata: served_id [29:0], zero [31:30];
//          |           | m_tuser: queue_empty [0]
// APB      | in/out    | population at byte address 0
//
// A serve is accepted, then write-back requeues the head entry at the tail.
// Expedite rebuilds the queue in the spare bank and restart fills min(population, DEPTH)
// entries; both walk the queue memory one entry per cycle through a bank's single write port.
// Reset clears the queue (empty, head at 0) and sets population to 1; memory is not cleared.
// A serve waits in write-back while the output register is still full and m_tready is low.
module move_to_front_service_queue #(
	parameter int DEPTH = mtfq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // cmd [1:0], target_id [31:2]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // served_id [29:0], zero fill [31:30]
	output logic [0:0]  m_tuser,   // queue_empty [0]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ID_W = mtfq_pkg::ID_W;
	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SW   = IW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRV_WB,
		ST_EXP_RUN,
		ST_EXP_DRAIN,
		ST_RESTART
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic              bank_q;      // bank holding the live queue
	logic [CW-1:0]     idx_q;       // walk index: expedite read, restart fill
	logic [CW-1:0]     lim_q;       // restart fill length
	logic [CW-1:0]     wcnt_q;      // expedite entries written to the spare bank
	logic [ID_W-1:0]   tgt_q;
	logic              rvalid_s1;
	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_empty_q;
	logic [ID_W-1:0]   pop_q;

	logic [mtfq_pkg::CMD_W-1:0] in_cmd;
	logic [ID_W-1:0]            in_id;
	logic                       in_acc;
	logic                       out_free;
	logic                       copy_ok;

	logic [ID_W-1:0] rd_data, rd_data0, rd_data1;
	logic [IW-1:0]   rd_addr;
	logic            wr_en, wr_other;
	logic [IW-1:0]   wr_addr;
	logic [ID_W-1:0] wr_data;

	logic [SW-1:0]   exp_sum, tail_sum;
	logic [IW-1:0]   exp_addr, tail_addr, head_next;
	logic [CW-1:0]   fill_len;

	assign in_cmd   = s_tdata[1:0];
	assign in_id    = s_tdata[31:2];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign rd_data = bank_q ? rd_data1 : rd_data0;

	// Circular addresses: sums stay below 2*DEPTH, so one subtract wraps them.
	assign exp_sum   = SW'(head_q) + SW'(idx_q);
	assign exp_addr  = (exp_sum >= SW'(DEPTH)) ? IW'(exp_sum - SW'(DEPTH)) : IW'(exp_sum);
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_addr = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
	assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);

	assign fill_len = (pop_q > ID_W'(DEPTH)) ? CW'(DEPTH) : CW'(pop_q);

	// Keep an entry unless it is the expedited id or the spare bank is full.
	assign copy_ok = rvalid_s1 && (rd_data != tgt_q) && (wcnt_q < CW'(DEPTH));

	// Idle and write-back keep reading the head, so a serve finds it in the registered read data.
	assign rd_addr = (state_q == ST_EXP_RUN) ? exp_addr : head_q;

	always_comb begin
		wr_en    = 1'b0;
		wr_other = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		if (in_acc && in_cmd == mtfq_pkg::CMD_EXPEDITE) begin
			// new front entry of the rebuilt queue
			wr_en    = 1'b1;
			wr_other = 1'b1;
			wr_data  = in_id;
		end else if ((state_q == ST_EXP_RUN || state_q == ST_EXP_DRAIN) && copy_ok) begin
			wr_en    = 1'b1;
			wr_other = 1'b1;
			wr_addr  = wcnt_q[IW-1:0];
			wr_data  = rd_data;
		end else if (state_q == ST_RESTART) begin
			wr_en   = 1'b1;
			wr_addr = idx_q[IW-1:0];
			wr_data = ID_W'(idx_q) + ID_W'(1);
		end else if (state_q == ST_SRV_WB && out_free && count_q != '0) begin
			// requeue the head at the tail
			wr_en   = 1'b1;
			wr_addr = tail_addr;
			wr_data = rd_data;
		end
	end

	mtfq_ram #(.DEPTH(DEPTH), .WIDTH(ID_W)) u_bank0 (
		.clk   (clk),
		.we    (wr_en && ((bank_q ^ wr_other) == 1'b0)),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data0)
	);

	mtfq_ram #(.DEPTH(DEPTH), .WIDTH(ID_W)) u_bank1 (
		.clk   (clk),
		.we    (wr_en && ((bank_q ^ wr_other) == 1'b1)),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data1)
	);

	// Control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			lim_q       <= '0;
			wcnt_q      <= '0;
			tgt_q       <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_empty_q <= 1'b0;
		end else begin
			// load the result when write-back retires, else drop it once the beat is taken
			if (state_q == ST_SRV_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			rvalid_s1 <= (state_q == ST_EXP_RUN) && (idx_q < count_q);
			if (copy_ok) begin
				wcnt_q <= wcnt_q + CW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_cmd)
							mtfq_pkg::CMD_SERVE: begin
								state_q <= ST_SRV_WB;
							end
							mtfq_pkg::CMD_EXPEDITE: begin
								tgt_q   <= in_id;
								idx_q   <= '0;
								wcnt_q  <= CW'(1);
								state_q <= ST_EXP_RUN;
							end
							mtfq_pkg::CMD_RESTART: begin
								if (fill_len == '0) begin
									head_q  <= '0;
									count_q <= '0;
								end else begin
									idx_q   <= '0;
									lim_q   <= fill_len;
									state_q <= ST_RESTART;
								end
							end
							default: begin
								// unused code: ignore the beat
							end
						endcase
					end
				end
				ST_SRV_WB: begin
					// hold until the output register can take the result
					if (out_free) begin
						if (count_q == '0) begin
							out_id_q    <= '0;
							out_empty_q <= 1'b1;
						end else begin
							out_id_q    <= rd_data;
							out_empty_q <= 1'b0;
							head_q      <= head_next;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EXP_RUN: begin
					// issue one read per cycle over the live entries
					if (idx_q < count_q) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= ST_EXP_DRAIN;
					end
				end
				ST_EXP_DRAIN: begin
					// last read lands, then swap banks
					if (!rvalid_s1) begin
						bank_q  <= ~bank_q;
						head_q  <= '0;
						count_q <= wcnt_q;
						state_q <= ST_IDLE;
					end
				end
				ST_RESTART: begin
					if (idx_q == lim_q - CW'(1)) begin
						head_q  <= '0;
						count_q <= lim_q;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= ID_W'(1);
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			pop_q <= pwdata[ID_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(pop_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 32'(out_id_q);
	assign m_tuser  = out_empty_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IW'(DEPTH - 1))
		else $error("head index out of range");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("empty serve carries a nonzero id");

	a_rd_in_exp: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == ST_EXP_RUN || state_q == ST_EXP_DRAIN))
		else $error("read data pending outside expedite walk");

	a_exp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXP_DRAIN && !rvalid_s1) |=> (count_q != '0))
		else $error("expedite left the queue empty");
`endif

endmodule

// ===== rtl/mtfq_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module mtfq_ram #(
	parameter int DEPTH = mtfq_pkg::DEPTH_DEF,
	parameter int WIDTH = mtfq_pkg::ID_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
